// File: rtl/uvc_pkg.sv
// Shared types and constants for the UTF-8 validator.
package uvc_pkg;

  // Depth of the queue between the classifier and the checker.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Range allowed for the next continuation byte. Codes 5 to 7 never arise
  // and are treated as the full continuation range.
  typedef enum logic [2:0] {
    RNG_ANY  = 3'd0,
    RNG_A0BF = 3'd1,
    RNG_809F = 3'd2,
    RNG_90BF = 3'd3,
    RNG_808F = 3'd4
  } rng_t;

  // Continuation ranges that a byte fits, one bit per range code.
  typedef struct packed {
    logic r808f;
    logic r90bf;
    logic r809f;
    logic ra0bf;
    logic rany;
  } fit_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic       last;
    logic       lead_ok;
    logic [1:0] lead_n;
    rng_t       lead_rng;
    fit_t       fit;
  } cls_word_t;

  localparam logic [7:0] B_7F = 8'h7F;
  localparam logic [7:0] B_80 = 8'h80;
  localparam logic [7:0] B_8F = 8'h8F;
  localparam logic [7:0] B_90 = 8'h90;
  localparam logic [7:0] B_9F = 8'h9F;
  localparam logic [7:0] B_A0 = 8'hA0;
  localparam logic [7:0] B_BF = 8'hBF;
  localparam logic [7:0] B_C1 = 8'hC1;
  localparam logic [7:0] B_C2 = 8'hC2;
  localparam logic [7:0] B_DF = 8'hDF;
  localparam logic [7:0] B_E0 = 8'hE0;
  localparam logic [7:0] B_E1 = 8'hE1;
  localparam logic [7:0] B_EC = 8'hEC;
  localparam logic [7:0] B_ED = 8'hED;
  localparam logic [7:0] B_EE = 8'hEE;
  localparam logic [7:0] B_EF = 8'hEF;
  localparam logic [7:0] B_F0 = 8'hF0;
  localparam logic [7:0] B_F1 = 8'hF1;
  localparam logic [7:0] B_F3 = 8'hF3;
  localparam logic [7:0] B_F4 = 8'hF4;

endpackage

// File: rtl/uvc_front.sv
// Front end: classifies each accepted byte as lead and as continuation.
module uvc_front
  import uvc_pkg::*;
(
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output cls_word_t  cls
);

  // Lead decode: number of continuation bytes and the first one's range.
  always_comb begin
    cls.last     = end_of_text;
    cls.lead_ok  = 1'b1;
    cls.lead_n   = 2'd0;
    cls.lead_rng = RNG_ANY;
    case (text_byte) inside
      [8'h00 : B_7F]: cls.lead_n = 2'd0;
      [B_80 : B_C1]:  cls.lead_ok = 1'b0;
      [B_C2 : B_DF]:  cls.lead_n = 2'd1;
      B_E0: begin
        cls.lead_n   = 2'd2;
        cls.lead_rng = RNG_A0BF;
      end
      [B_E1 : B_EC]:  cls.lead_n = 2'd2;
      B_ED: begin
        cls.lead_n   = 2'd2;
        cls.lead_rng = RNG_809F;
      end
      [B_EE : B_EF]:  cls.lead_n = 2'd2;
      B_F0: begin
        cls.lead_n   = 2'd3;
        cls.lead_rng = RNG_90BF;
      end
      [B_F1 : B_F3]:  cls.lead_n = 2'd3;
      B_F4: begin
        cls.lead_n   = 2'd3;
        cls.lead_rng = RNG_808F;
      end
      default:        cls.lead_ok = 1'b0;
    endcase

    // Continuation ranges this byte falls into.
    cls.fit.rany  = (text_byte >= B_80) && (text_byte <= B_BF);
    cls.fit.ra0bf = (text_byte >= B_A0) && (text_byte <= B_BF);
    cls.fit.r809f = (text_byte >= B_80) && (text_byte <= B_9F);
    cls.fit.r90bf = (text_byte >= B_90) && (text_byte <= B_BF);
    cls.fit.r808f = (text_byte >= B_80) && (text_byte <= B_8F);
  end

endmodule

// File: rtl/uvc_queue.sv
// Short queue of classified words between the front and the back.
module uvc_queue
  import uvc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_word_t push_word,
  output logic      full,
  input  logic      pop,
  output cls_word_t pop_word,
  output logic      empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cls_word_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = mem_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// File: rtl/uvc_back.sv
// Back end: sequence tracking, sticky error and the registered result word.
module uvc_back
  import uvc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cls_word_t cls,
  input  logic      cls_avail,
  output logic      cls_pop,
  output logic      ok_so_far,
  output logic      verdict_final,
  output logic      res_valid,
  input  logic      res_ready
);

  logic [1:0] pend_r, pend_nxt;
  rng_t       rng_r, rng_nxt;
  logic       err_r, err_nxt;
  logic       ok_r, ok_nxt;
  logic       fin_r, fin_nxt;
  logic       vld_r, vld_nxt;
  logic       fit;
  logic       pend_after;

  // The output register takes a new word when it is empty or being drained.
  assign cls_pop = cls_avail && (!vld_r || res_ready);

  // Does the byte fit the range the current sequence allows?
  always_comb begin
    case (rng_r)
      RNG_A0BF: fit = cls.fit.ra0bf;
      RNG_809F: fit = cls.fit.r809f;
      RNG_90BF: fit = cls.fit.r90bf;
      RNG_808F: fit = cls.fit.r808f;
      default:  fit = cls.fit.rany;
    endcase
  end

  // Next state of the checker for the word being popped.
  always_comb begin
    pend_nxt   = pend_r;
    rng_nxt    = rng_r;
    err_nxt    = err_r;
    ok_nxt     = ok_r;
    fin_nxt    = fin_r;
    vld_nxt    = vld_r && !res_ready;
    pend_after = 1'b0;
    if (cls_pop) begin
      if (!err_r) begin
        if (pend_r != 2'd0) begin
          if (fit) begin
            pend_nxt = pend_r - 2'd1;
            rng_nxt  = RNG_ANY;
          end else begin
            err_nxt = 1'b1;
          end
        end else if (cls.lead_ok) begin
          pend_nxt = cls.lead_n;
          rng_nxt  = cls.lead_rng;
        end else begin
          err_nxt = 1'b1;
        end
        if (err_nxt) begin
          pend_nxt = 2'd0;
          rng_nxt  = RNG_ANY;
        end
      end
      pend_after = (pend_nxt != 2'd0);
      ok_nxt     = !err_nxt && !(cls.last && pend_after);
      fin_nxt    = cls.last;
      vld_nxt    = 1'b1;
      // Re-arm for the next text after its last byte.
      if (cls.last) begin
        pend_nxt = 2'd0;
        rng_nxt  = RNG_ANY;
        err_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      rng_r  <= RNG_ANY;
      err_r  <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      rng_r  <= rng_nxt;
      err_r  <= err_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    ok_r  <= ok_nxt;
    fin_r <= fin_nxt;
  end

  assign ok_so_far     = ok_r;
  assign verdict_final = fin_r;
  assign res_valid     = vld_r;

endmodule

// File: rtl/utf8_strict_validator_core.sv
// Top level of the strict UTF-8 validator: classifier, queue and checker.
//
//  Channel | Direction | tdata (low bit up)     | tlast
//  in_     | slave     | [7:0] text_byte        | end_of_text
//  out_    | master    | [0] ok_so_far, 7'b0    | verdict_final
//
// One byte is accepted per cycle while in_tready is high, and one result
// word leaves per cycle while out_tready is high. A result passes through
// the queue and then the output register of the checker. Reset (rst_n low,
// synchronous) empties the queue and clears the checker state and the output
// valid. When out_tready is low the queue absorbs up to its depth of words
// before in_tready drops.
module utf8_strict_validator_core
  import uvc_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] ok_so_far, [7:1] zero
  output logic       out_tlast
);

  cls_word_t front_word, back_word;
  logic      q_full, q_empty, q_pop;
  logic      ok_so_far;

  uvc_front u_front (
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .cls         (front_word)
  );

  uvc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_word (front_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (back_word),
    .empty     (q_empty)
  );

  uvc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cls           (back_word),
    .cls_avail     (!q_empty),
    .cls_pop       (q_pop),
    .ok_so_far     (ok_so_far),
    .verdict_final (out_tlast),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready)
  );

  assign in_tready = !q_full;
  assign out_tdata = {7'b0, ok_so_far};

endmodule
